>>> sv/name_hash_slot_assigner_defines.svh
// ----------------------------------------------------------------------------
// Name hash slot assigner assertion macros
// Concurrent assertion wrappers. They compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NAME_HASH_SLOT_ASSIGNER_DEFINES_SVH
`define NAME_HASH_SLOT_ASSIGNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when pre holds, post must hold on the same edge.
`define NHSA_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("nhsa assertion failed");
// Next-cycle implication: when pre holds, post must hold on the next edge.
`define NHSA_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("nhsa assertion failed");
`else
`define NHSA_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define NHSA_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

>>> sv/nhsa_pkg.sv
// ----------------------------------------------------------------------------
// Name hash slot assigner package
// Shared constants, state encoding and control structs.
// ----------------------------------------------------------------------------
package nhsa_pkg;

	localparam int MAX_SLOTS = 32;
	localparam int SLOT_W    = 5;
	localparam int SIZE_W    = 6;
	localparam int HASH_W    = 32;
	localparam int CNT_W     = 6;

	localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;

	localparam logic [7:0] CHAR_SLASH     = 8'h2F;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
	localparam logic [7:0] CASE_OFFSET    = 8'h20;

	localparam logic FUNC_BYTE  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic REG_PALETTE_SIZE = 1'b0;
	localparam logic REG_SEQ_MODE     = 1'b1;

	localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST = 6'd20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS_MOD,
		ST_HASH_MOD,
		ST_PROBE,
		ST_FINISH
	} nhsa_state_t;

	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  steps;
		logic [HASH_W-1:0] dividend;
	} rem_ctrl_t;

	typedef struct packed {
		logic              busy;
		logic [SLOT_W-1:0] rem;
	} rem_stat_t;

	// A programmed size of zero behaves as one, anything above the slot count as the maximum.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] s;
		s = raw;
		if (s == '0)
			s = SIZE_W'(1);
		if (s > SIZE_W'(MAX_SLOTS))
			s = SIZE_W'(MAX_SLOTS);
		return s;
	endfunction

endpackage

>>> sv/nhsa_if.sv
// ----------------------------------------------------------------------------
// Name hash slot assigner channel interfaces
// Valid/ready channels for name bytes, slot results and register writes.
// ----------------------------------------------------------------------------
interface nhsa_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] name_byte;
	logic       last_byte;

	modport source (output valid, func, name_byte, last_byte, input ready);
	modport sink   (input valid, func, name_byte, last_byte, output ready);
endinterface

interface nhsa_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] slot;
	logic       reused;

	modport source (output valid, slot, reused, input ready);
	modport sink   (input valid, slot, reused, output ready);
endinterface

interface nhsa_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [5:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/nhsa_hash_unit.sv
// ----------------------------------------------------------------------------
// Name hash unit
// Running FNV-1a hash over lowercased bytes; separators restart the base name.
// ----------------------------------------------------------------------------
module nhsa_hash_unit
	import nhsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_en,
	input  logic [7:0]        name_byte,
	input  logic              restart,
	output logic [HASH_W-1:0] hash
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_d;
	logic [7:0]        folded;
	logic [HASH_W-1:0] mixed;

	always_comb begin
		folded = name_byte;
		if (name_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
			folded = name_byte + CASE_OFFSET;
		mixed = hash_q ^ {{(HASH_W-8){1'b0}}, folded};
		if (name_byte == CHAR_SLASH || name_byte == CHAR_BACKSLASH)
			hash_d = HASH_BASIS;
		else
			hash_d = HASH_W'(mixed * HASH_PRIME);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_BASIS;
		end else if (restart) begin
			hash_q <= HASH_BASIS;
		end else if (byte_en) begin
			hash_q <= hash_d;
		end
	end

	assign hash = hash_q;

endmodule

>>> sv/nhsa_rem_unit.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Shared restoring remainder engine, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module nhsa_rem_unit
	import nhsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rem_ctrl_t         ctrl,
	input  logic [SIZE_W-1:0] divisor,
	output rem_stat_t         stat
);

	logic [HASH_W-1:0] shift_q;
	logic [SLOT_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] trial;
	logic [SIZE_W-1:0] reduced;

	// The remainder stays below the divisor, so the shifted trial value fits six bits.
	always_comb begin
		trial   = {rem_q, shift_q[HASH_W-1]};
		reduced = (trial >= divisor) ? (trial - divisor) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= ctrl.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			shift_q <= ctrl.dividend;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[HASH_W-2:0], 1'b0};
			rem_q   <= reduced[SLOT_W-1:0];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.rem  = rem_q;

endmodule

>>> sv/name_hash_slot_assigner.sv
// A name byte without the last mark is taken one byte per cycle while the block is idle.
// A last byte starts a run position reduction and, in stable mode, a hash reduction and a
// probe of 1 to size slots, which is skipped when the palette is exhausted.
// Both reductions use the shared bit-serial remainder unit: 5 steps, then 32 steps.
// Reset clears the hash to the offset basis, empties the run and restores size 20, stable mode.
// ----------------------------------------------------------------------------
// Name hash slot assigner
// Hashes file base names and hands out palette slots, stable or in run order.
// ----------------------------------------------------------------------------
module name_hash_slot_assigner
	import nhsa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	nhsa_cfg_if.sink      cfg,
	nhsa_item_if.sink     item,
	nhsa_result_if.source result
);

`include "name_hash_slot_assigner_defines.svh"

	// Configuration registers. Writes are always accepted.
	logic [SIZE_W-1:0] palette_size_q;
	logic              seq_mode_q;
	logic [SIZE_W-1:0] size_eff;

	// Run state: the taken bitmap is a row of flip-flops so a clear is immediate.
	logic [MAX_SLOTS-1:0] taken_q;
	logic [SIZE_W-1:0]    placed_q;
	logic [SLOT_W-1:0]    run_pos_q;

	// Per-name working registers.
	logic [SLOT_W-1:0] pos_q;
	logic [SLOT_W-1:0] want_q;
	logic [SLOT_W-1:0] cand_q;
	logic [SLOT_W-1:0] probe_cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic              reused_q;

	// Output register, which lets the next name start while a result waits.
	logic              res_valid_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_reused_q;

	nhsa_state_t state_q;
	nhsa_state_t state_d;

	logic              item_acc;
	logic              byte_acc;
	logic              clear_acc;
	logic              out_free;
	logic              finish_go;
	logic              hash_restart;
	logic [HASH_W-1:0] hash;
	rem_ctrl_t         rem_ctrl;
	rem_stat_t         rem_stat;
	logic              cand_free;
	logic              probe_last;
	logic [SLOT_W-1:0] cand_next;
	logic [SLOT_W-1:0] pos_next;
	logic              exhausted;

	assign size_eff = eff_size(palette_size_q);

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);

	assign item_acc  = item.valid && item.ready;
	assign byte_acc  = item_acc && (item.func == FUNC_BYTE);
	assign clear_acc = item_acc && (item.func == FUNC_CLEAR);
	assign out_free  = !res_valid_q || result.ready;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	// The hash starts over after every finished name and on a run clear.
	assign hash_restart = finish_go || clear_acc;

	// Probing walks forward one slot a cycle and wraps at the effective size.
	assign cand_free  = !taken_q[cand_q];
	assign probe_last = (({1'b0, probe_cnt_q} + SIZE_W'(1)) == size_eff);
	assign cand_next  = (({1'b0, cand_q} + SIZE_W'(1)) == size_eff) ? '0 : cand_q + SLOT_W'(1);
	assign pos_next   = (({1'b0, pos_q} + SIZE_W'(1)) == size_eff) ? '0 : pos_q + SLOT_W'(1);
	assign exhausted  = (placed_q >= size_eff);

	nhsa_hash_unit u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_acc),
		.name_byte (item.name_byte),
		.restart   (hash_restart),
		.hash      (hash)
	);

	nhsa_rem_unit u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (rem_ctrl),
		.divisor (size_eff),
		.stat    (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer. On the last byte the run position is reduced first, since the
	// size may have changed since it was stored. In stable mode the hash is then
	// reduced and, unless the palette is exhausted, the bitmap is probed.
	always_comb begin
		state_d           = state_q;
		rem_ctrl.start    = 1'b0;
		rem_ctrl.steps    = '0;
		rem_ctrl.dividend = '0;
		case (state_q)
			ST_IDLE: begin
				if (byte_acc && item.last_byte) begin
					rem_ctrl.start    = 1'b1;
					rem_ctrl.steps    = CNT_W'(SLOT_W);
					rem_ctrl.dividend = {run_pos_q, {(HASH_W-SLOT_W){1'b0}}};
					state_d           = ST_POS_MOD;
				end
			end
			ST_POS_MOD: begin
				if (!rem_stat.busy) begin
					if (seq_mode_q) begin
						state_d = ST_FINISH;
					end else begin
						rem_ctrl.start    = 1'b1;
						rem_ctrl.steps    = CNT_W'(HASH_W);
						rem_ctrl.dividend = hash;
						state_d           = ST_HASH_MOD;
					end
				end
			end
			ST_HASH_MOD: begin
				if (!rem_stat.busy)
					state_d = exhausted ? ST_FINISH : ST_PROBE;
			end
			ST_PROBE: begin
				if (cand_free || probe_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PALETTE_SIZE_RST;
			seq_mode_q     <= 1'b0;
			taken_q        <= '0;
			placed_q       <= '0;
			run_pos_q      <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PALETTE_SIZE: palette_size_q <= cfg.data;
					REG_SEQ_MODE:     seq_mode_q     <= cfg.data[0];
					default:          palette_size_q <= palette_size_q;
				endcase
			end
			if (clear_acc) begin
				taken_q   <= '0;
				placed_q  <= '0;
				run_pos_q <= '0;
			end
			if (state_q == ST_PROBE) begin
				if (cand_free) begin
					taken_q[cand_q] <= 1'b1;
					placed_q        <= placed_q + SIZE_W'(1);
				end else if (probe_last) begin
					// The size shrank under a partly filled run: mark it exhausted.
					placed_q <= size_eff;
				end
			end
			if (finish_go)
				run_pos_q <= pos_next;
		end
	end

	// Per-name working registers; each is loaded before it is used.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_POS_MOD: begin
				if (!rem_stat.busy) begin
					pos_q    <= rem_stat.rem;
					slot_q   <= rem_stat.rem;
					reused_q <= 1'b0;
				end
			end
			ST_HASH_MOD: begin
				if (!rem_stat.busy) begin
					want_q      <= rem_stat.rem;
					cand_q      <= rem_stat.rem;
					slot_q      <= rem_stat.rem;
					probe_cnt_q <= '0;
					reused_q    <= exhausted;
				end
			end
			ST_PROBE: begin
				if (cand_free) begin
					slot_q <= cand_q;
				end else if (probe_last) begin
					slot_q   <= want_q;
					reused_q <= 1'b1;
				end else begin
					cand_q      <= cand_next;
					probe_cnt_q <= probe_cnt_q + SLOT_W'(1);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish_go) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			res_slot_q   <= slot_q;
			res_reused_q <= reused_q;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.slot   = res_slot_q;
	assign result.reused = res_reused_q;

	// A waiting result always names a slot inside the current palette.
	`NHSA_ASSERT_IMP(a_slot_in_range, clk, arst_n, res_valid_q, {1'b0, res_slot_q} < size_eff)
	// Sequential mode never reports reuse.
	`NHSA_ASSERT_IMP(a_seq_no_reuse, clk, arst_n, res_valid_q && seq_mode_q, !res_reused_q)
	// A clear word empties the run on the next edge.
	`NHSA_ASSERT_NXT(a_clear_empties, clk, arst_n, clear_acc, taken_q == '0 && placed_q == '0)
	// The probe never walks past the palette.
	`NHSA_ASSERT_IMP(a_probe_bound, clk, arst_n, state_q == ST_PROBE, {1'b0, probe_cnt_q} < size_eff)

endmodule
